/* hdl/rhc_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
`timescale 1ns / 1ps

package rhc_pkg;

	localparam int CH_W    = 16;   // channel count width
	localparam int HUE_W   = 15;
	localparam int SAT_W   = 16;
	localparam int VAL_W   = 17;
	localparam int DIV_NW  = 32;   // partial remainder width
	localparam int DIV_QW  = 16;   // quotient bits, one per divider stage

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	localparam logic [HUE_W-1:0] HUE_OFF_GREEN = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_OFF_BLUE  = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_FULL_TURN = 15'd23040;

	typedef struct packed {
		logic [DIV_NW-1:0] rem;
		logic [CH_W-1:0]   dvs;
		logic [DIV_QW-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		logic [1:0]       sector;
		logic             neg;
		logic             gray;
		logic [VAL_W-1:0] value;
	} side_t;

	typedef struct packed {
		div_lane_t sat;
		div_lane_t hue;
		side_t     side;
	} div_word_t;

endpackage

/* hdl/rgb_to_hsv_converter_unit.sv */
// Top level of the RGB to HSV converter.
`timescale 1ns / 1ps

// Converts one pixel of 16-bit red, green and blue counts into hue (1/64 degree),
// saturation (32768 means 1.0) and value (max / 255 in 1/256 units).
// Input: drive red, green and blue with start high; the item is taken at that
// clock edge whenever busy is low. Busy never rises, so an item may enter at
// every clock edge.
// Output: each result is on hue, saturation and value for exactly one cycle
// with done high. Results come out in input order and the receiver must take
// them as they come; there is no way to hold them off.
// Pipeline from the accepting edge to the done cycle: two front stages for the
// channel compare and the divider operands, sixteen divider stages that each
// settle one quotient bit of both the saturation and the hue division, and one
// output register.
// Throughput is one item per clock.
// Reset clears every valid bit in the pipeline, so items in flight are
// dropped and done stays low until new items arrive.
module rgb_to_hsv_converter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [rhc_pkg::CH_W-1:0]  red,
	input  logic [rhc_pkg::CH_W-1:0]  green,
	input  logic [rhc_pkg::CH_W-1:0]  blue,
	output logic                      done,
	output logic [rhc_pkg::HUE_W-1:0] hue,
	output logic [rhc_pkg::SAT_W-1:0] saturation,
	output logic [rhc_pkg::VAL_W-1:0] value
);
	import rhc_pkg::*;

	logic      front_valid;
	div_word_t front_word;
	logic      div_valid;
	div_word_t div_word;

	assign busy = 1'b0;

	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (front_valid),
		.out_word  (front_word)
	);

	rhc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_word   (front_word),
		.out_valid (div_valid),
		.out_word  (div_word)
	);

	rhc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (div_valid),
		.in_word    (div_word),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.value      (value)
	);

endmodule

/* hdl/rhc_front.sv */
// Front end: channel compare, sector pick, value and divider operands.
`timescale 1ns / 1ps

module rhc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [rhc_pkg::CH_W-1:0] red,
	input  logic [rhc_pkg::CH_W-1:0] green,
	input  logic [rhc_pkg::CH_W-1:0] blue,
	output logic                    out_valid,
	output rhc_pkg::div_word_t      out_word
);
	import rhc_pkg::*;

	logic             r_ge_g, r_ge_b, g_ge_b;
	logic [1:0]       sector;
	logic [CH_W-1:0]  mx, mn;
	logic [CH_W:0]    diff;

	logic             valid_s1;
	logic [1:0]       sector_s1;
	logic [CH_W-1:0]  mx_s1, mn_s1;
	logic [CH_W:0]    diff_s1;

	logic [CH_W-1:0]  delta;
	logic             neg;
	logic [CH_W-1:0]  absdiff;
	logic [CH_W:0]    mx_p1;
	logic [25:0]      prod;
	logic [27:0]      hue_num;
	div_word_t        word;

	logic             valid_s2;
	div_word_t        word_s2;

	always_comb begin
		r_ge_g = red >= green;
		r_ge_b = red >= blue;
		g_ge_b = green >= blue;
		// The first largest channel in red, green, blue order picks the sector.
		if (r_ge_g && r_ge_b) begin
			sector = SEC_RED;
			mx     = red;
			diff   = {1'b0, green} - {1'b0, blue};
		end else if (g_ge_b) begin
			sector = SEC_GREEN;
			mx     = green;
			diff   = {1'b0, blue} - {1'b0, red};
		end else begin
			sector = SEC_BLUE;
			mx     = blue;
			diff   = {1'b0, red} - {1'b0, green};
		end
		if (!r_ge_g && !r_ge_b)
			mn = red;
		else if (g_ge_b)
			mn = blue;
		else
			mn = green;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= sector;
		mx_s1     <= mx;
		mn_s1     <= mn;
		diff_s1   <= diff;
	end

	always_comb begin
		delta   = mx_s1 - mn_s1;
		neg     = diff_s1[CH_W];
		absdiff = neg ? CH_W'(-diff_s1) : diff_s1[CH_W-1:0];
		// floor(mx / 255) is ((mx + 1) * 257) >> 16 over the whole 16-bit range.
		mx_p1   = {1'b0, mx_s1} + 17'd1;
		prod    = {1'b0, mx_p1, 8'b0} + 26'(mx_p1);
		// Sixty degrees is 3840 = 4096 - 256 hue units.
		hue_num = {absdiff, 12'b0} - {4'b0, absdiff, 8'b0};

		word.sat.rem    = DIV_NW'({delta, 15'b0});
		word.sat.dvs    = mx_s1;
		word.sat.quo    = '0;
		word.hue.rem    = DIV_NW'(hue_num);
		word.hue.dvs    = delta;
		word.hue.quo    = '0;
		word.side.sector = sector_s1;
		word.side.neg    = neg;
		word.side.gray   = (delta == '0);
		word.side.value  = VAL_W'(mx_s1) + VAL_W'(prod[25:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word;
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

/* hdl/rhc_div_pipe.sv */
// Dual-lane restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module rhc_div_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  rhc_pkg::div_word_t in_word,
	output logic               out_valid,
	output rhc_pkg::div_word_t out_word
);
	import rhc_pkg::*;

	logic      stg_valid_s [1:DIV_QW];
	div_word_t stg_word_s  [1:DIV_QW];

	genvar i;
	generate
		for (i = 0; i < DIV_QW; i++) begin : g_stage
			localparam int K = DIV_QW - 1 - i;
			logic              cur_valid;
			div_word_t         cur;
			logic [DIV_NW-1:0] sat_sh, hue_sh;
			logic              sat_ge, hue_ge;
			div_word_t         nxt;

			if (i == 0) begin : g_head
				assign cur_valid = in_valid;
				assign cur       = in_word;
			end else begin : g_body
				assign cur_valid = stg_valid_s[i];
				assign cur       = stg_word_s[i];
			end

			always_comb begin
				sat_sh = DIV_NW'(cur.sat.dvs) << K;
				hue_sh = DIV_NW'(cur.hue.dvs) << K;
				sat_ge = cur.sat.rem >= sat_sh;
				hue_ge = cur.hue.rem >= hue_sh;
				nxt    = cur;
				// The remainder stays below dvs << (K + 1), so one compare decides bit K.
				if (sat_ge) begin
					nxt.sat.rem    = cur.sat.rem - sat_sh;
					nxt.sat.quo[K] = 1'b1;
				end
				if (hue_ge) begin
					nxt.hue.rem    = cur.hue.rem - hue_sh;
					nxt.hue.quo[K] = 1'b1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stg_valid_s[i+1] <= 1'b0;
				end else begin
					stg_valid_s[i+1] <= cur_valid;
				end
			end

			always_ff @(posedge clk) begin
				stg_word_s[i+1] <= nxt;
			end
		end
	endgenerate

	assign out_valid = stg_valid_s[DIV_QW];
	assign out_word  = stg_word_s[DIV_QW];

endmodule

/* hdl/rhc_back.sv */
// Back end: hue offset and wrap, gray override and result register.
`timescale 1ns / 1ps

module rhc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  rhc_pkg::div_word_t        in_word,
	output logic                      done,
	output logic [rhc_pkg::HUE_W-1:0] hue,
	output logic [rhc_pkg::SAT_W-1:0] saturation,
	output logic [rhc_pkg::VAL_W-1:0] value
);
	import rhc_pkg::*;

	logic [HUE_W-1:0] hq;
	logic [HUE_W-1:0] base;
	logic [HUE_W-1:0] hue_d;
	logic [SAT_W-1:0] sat_d;

	logic             done_q;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [VAL_W-1:0] value_q;

	always_comb begin
		hq = in_word.hue.quo[HUE_W-1:0];
		case (in_word.side.sector)
			SEC_RED:   base = '0;
			SEC_GREEN: base = HUE_OFF_GREEN;
			SEC_BLUE:  base = HUE_OFF_BLUE;
			default:   base = '0;
		endcase
		if (in_word.side.gray) begin
			hue_d = '0;
		end else if (in_word.side.neg) begin
			// Only the red sector can go below zero; it wraps by a full turn.
			if (in_word.side.sector == SEC_RED)
				hue_d = (hq == '0) ? '0 : HUE_FULL_TURN - hq;
			else
				hue_d = base - hq;
		end else begin
			hue_d = base + hq;
		end
		sat_d = in_word.side.gray ? '0 : in_word.sat.quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		hue_q   <= hue_d;
		sat_q   <= sat_d;
		value_q <= in_word.side.value;
	end

	assign done       = done_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign value      = value_q;

endmodule
